### hdl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; every other file imports this package.
`default_nettype none
package wbps_pkg;

   // Pattern and address sizing
   localparam int PATTERN_MAX   = 16;
   localparam int ADDR_BITS     = 48;
   localparam int CARE_BITS     = 16;
   localparam int WIN_DEPTH     = PATTERN_MAX - 1;
   localparam int LENM1_BITS    = $clog2(PATTERN_MAX);
   localparam int FILL_BITS     = $clog2(PATTERN_MAX + 1);
   localparam int LEN_REG_BITS  = 5;

   // Queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_IDX_BITS  = 3;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CARE_MASK    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_REGION_BASE  = 3'd4;

   typedef struct packed {
      logic [63:0]             pattern_low;
      logic [63:0]             pattern_high;
      logic [CARE_BITS-1:0]    care_mask;
      logic [LEN_REG_BITS-1:0] pattern_length;
      logic [ADDR_BITS-1:0]    region_base;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

### hdl/wbps_csr.sv
// Configuration registers of the scanner behind an APB-style port.
// Depends on wbps_pkg for the register map and the cfg_type struct.
`default_nettype none
module wbps_csr
   import wbps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type                 cfg_ff;
   logic                    wr_en;
   logic [CSR_IDX_BITS-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_BITS-1 -: CSR_IDX_BITS];
   assign cfg     = cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.care_mask      <= '0;
         cfg_ff.pattern_length <= LEN_REG_BITS'(1);
         cfg_ff.region_base    <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PATTERN_LOW:  cfg_ff.pattern_low    <= pwdata;
            REG_PATTERN_HIGH: cfg_ff.pattern_high   <= pwdata;
            REG_CARE_MASK:    cfg_ff.care_mask      <= pwdata[CARE_BITS-1:0];
            REG_PATTERN_LEN:  cfg_ff.pattern_length <= pwdata[LEN_REG_BITS-1:0];
            REG_REGION_BASE:  cfg_ff.region_base    <= pwdata[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_PATTERN_LOW:  prdata = cfg_ff.pattern_low;
         REG_PATTERN_HIGH: prdata = cfg_ff.pattern_high;
         REG_CARE_MASK:    prdata = CSR_DATA_BITS'(cfg_ff.care_mask);
         REG_PATTERN_LEN:  prdata = CSR_DATA_BITS'(cfg_ff.pattern_length);
         REG_REGION_BASE:  prdata = CSR_DATA_BITS'(cfg_ff.region_base);
         default:          prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

### hdl/wbps_front.sv
// Front end: accepts bytes, keeps the sliding window and fill/offset state,
// compares the window with the pattern and pushes hit start offsets.
// Depends on wbps_pkg.
`default_nettype none
module wbps_front
   import wbps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_region_begin,
   input  wire qstat_type            qstat,
   output logic                      push_valid,
   output logic      [ADDR_BITS-1:0] push_offset
);

   logic [7:0]           win_ff [WIN_DEPTH];
   logic [FILL_BITS-1:0] fill_ff, fill_in, fill_base;
   logic [ADDR_BITS-1:0] offset_ff, offset_in, offset_base;
   logic [FILL_BITS-1:0] eff_len;
   logic [LENM1_BITS-1:0] lenm1;
   logic [PATTERN_MAX-1:0] pos_ok;
   logic                 accept;
   logic                 hit;

   assign req_ready = ~qstat.full;
   assign accept    = req_valid & req_ready;

   // Effective length: zero acts as one, large values clamp
   always_comb begin
      if (cfg.pattern_length == '0) begin
         eff_len = FILL_BITS'(1);
      end else if (FILL_BITS'(cfg.pattern_length) > FILL_BITS'(PATTERN_MAX)) begin
         eff_len = FILL_BITS'(PATTERN_MAX);
      end else begin
         eff_len = FILL_BITS'(cfg.pattern_length);
      end
      lenm1 = LENM1_BITS'(eff_len - FILL_BITS'(1));
   end

   // Region restart and saturating fill count
   always_comb begin
      fill_base   = req_region_begin ? '0 : fill_ff;
      offset_base = req_region_begin ? '0 : offset_ff;
      fill_in     = (fill_base == FILL_BITS'(PATTERN_MAX)) ? fill_base
                                                          : fill_base + FILL_BITS'(1);
      offset_in   = offset_base + ADDR_BITS'(1);
   end

   // Per-position compare; the current byte is the last position
   always_comb begin
      logic [7:0]            seen;
      logic [7:0]            want;
      logic [LENM1_BITS-1:0] idx;
      for (int p = 0; p < PATTERN_MAX; p++) begin
         idx  = LENM1_BITS'(int'(lenm1) - 1 - p);
         seen = (LENM1_BITS'(p) == lenm1) ? req_data_byte
                                          : win_ff[idx[LENM1_BITS-1:0]];
         if (p < 8) begin
            want = cfg.pattern_low[8*(p % 8) +: 8];
         end else begin
            want = cfg.pattern_high[8*(p % 8) +: 8];
         end
         if (p >= CARE_BITS || p > int'(lenm1)) begin
            pos_ok[p] = 1'b1;
         end else begin
            pos_ok[p] = ~cfg.care_mask[p % CARE_BITS] || (seen == want);
         end
      end
      hit = (&pos_ok) && (fill_in >= eff_len);
   end

   assign push_valid  = accept & hit;
   assign push_offset = offset_base - ADDR_BITS'(lenm1);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         offset_ff <= '0;
      end else if (accept) begin
         fill_ff   <= fill_in;
         offset_ff <= offset_in;
      end
   end

   // Window shift, newest byte at entry zero
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff[0] <= req_data_byte;
         for (int i = 1; i < WIN_DEPTH; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

endmodule
`default_nettype wire

### hdl/wbps_queue.sv
// Short FIFO of hit start offsets between the front and back ends.
// Depends on wbps_pkg.
`default_nettype none
module wbps_queue
   import wbps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire logic [ADDR_BITS-1:0] push_offset,
   input  wire logic                 pop,
   output logic      [ADDR_BITS-1:0] pop_offset,
   output qstat_type                 qstat
);

   logic [ADDR_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, rptr_ff;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push_valid & ~qstat.full;
   assign do_pop      = pop & ~qstat.empty;
   assign pop_offset  = entry_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= wptr_ff + QPTR_BITS'(1);
         if (do_pop)  rptr_ff <= rptr_ff + QPTR_BITS'(1);
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_offset;
      end
   end

endmodule
`default_nettype wire

### hdl/wbps_back.sv
// Back end: pops hit offsets, adds the region base and holds the result
// item in the output register. Depends on wbps_pkg.
`default_nettype none
module wbps_back
   import wbps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire qstat_type            qstat,
   input  wire logic [ADDR_BITS-1:0] pop_offset,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [ADDR_BITS-1:0] rsp_match_address
);

   logic                 valid_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   // Load when the output slot is free or being drained this cycle
   assign pop               = ~qstat.empty & (~valid_ff | rsp_ready);
   assign rsp_valid         = valid_ff;
   assign rsp_match_address = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Address sum wraps at the address width
   always_ff @(posedge clock) begin
      if (pop) begin
         addr_ff <= cfg.region_base + pop_offset;
      end
   end

endmodule
`default_nettype wire

### hdl/wildcard_byte_pattern_scanner_core.sv
// Top level of the wildcard byte pattern scanner: registers, front end,
// queue and back end. Depends on wbps_pkg and the wbps_* modules.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_data_byte, req_region_begin
//   rsp       out        rsp_valid/rsp_ready   rsp_match_address
//   csr       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One byte is taken per cycle while req_ready is high; the window compare is in
// the accept cycle. A match passes the queue, then the adder register, to rsp.
// Reset is synchronous; registers return to their defaults, queue empties.
// A stalled rsp fills the four-entry hit queue; req_ready drops only when full.
`default_nettype none
module wildcard_byte_pattern_scanner_core
   import wbps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_region_begin,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic      [ADDR_BITS-1:0]     rsp_match_address,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cfg_type              cfg;
   qstat_type            qstat;
   logic                 push_valid;
   logic [ADDR_BITS-1:0] push_offset;
   logic                 pop;
   logic [ADDR_BITS-1:0] pop_offset;

   wbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wbps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_region_begin (req_region_begin),
      .qstat            (qstat),
      .push_valid       (push_valid),
      .push_offset      (push_offset)
   );

   wbps_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_offset (push_offset),
      .pop         (pop),
      .pop_offset  (pop_offset),
      .qstat       (qstat)
   );

   wbps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .qstat             (qstat),
      .pop_offset        (pop_offset),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_address (rsp_match_address)
   );

endmodule
`default_nettype wire

### hdl/wbps_checker.sv
// Port-level checker for the scanner core, attached by the bind below.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner_core.
`default_nettype none
module wbps_checker
   import wbps_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [ADDR_BITS-1:0] rsp_match_address,
   input wire logic                 pready
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_address))
      else $error("rsp item changed while stalled");

   // Reset empties the output slot
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // Input stalls only while a result item is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty output");

   // A new result item must trace back to an accepted byte
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp item without a matching byte");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_match_address (rsp_match_address),
   .pready            (pready)
);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_scanner_core.
// Depends on wbps_pkg and the scanner RTL; a scoreboard class predicts match addresses.
module testbench;
   import wbps_pkg::*;

   localparam int RANDOM_ITEMS   = 1650;
   localparam int PHASE_ITEMS    = 110;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;

   // Match predictor plus the queue of match addresses still to arrive
   class scan_scoreboard;
      logic [7:0]           window [WIN_DEPTH];
      int unsigned          fill;
      logic [ADDR_BITS-1:0] offset;
      cfg_type              cfg;
      logic [ADDR_BITS-1:0] pending_matches [$];
      int unsigned          error_count;

      function new();
         foreach (window[i]) window[i] = 8'h00;
         fill = 0;
         offset = '0;
         cfg = '0;
         cfg.pattern_length = LEN_REG_BITS'(1);
         error_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [63:0] value);
         case (idx)
            REG_PATTERN_LOW:  cfg.pattern_low = value;
            REG_PATTERN_HIGH: cfg.pattern_high = value;
            REG_CARE_MASK:    cfg.care_mask = value[CARE_BITS-1:0];
            REG_PATTERN_LEN:  cfg.pattern_length = value[LEN_REG_BITS-1:0];
            REG_REGION_BASE:  cfg.region_base = value[ADDR_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Length in use: zero acts as one, oversize clamps
      function int used_length();
         int len;
         len = cfg.pattern_length;
         if (len == 0) len = 1;
         if (len > PATTERN_MAX) len = PATTERN_MAX;
         return len;
      endfunction

      function logic [7:0] expected_byte(int pos);
         if (pos >= CARE_BITS) return 8'h00;
         if (pos < 8) return 8'(cfg.pattern_low >> (8 * pos));
         return 8'(cfg.pattern_high >> (8 * (pos - 8)));
      endfunction

      function bit position_ok(int pos, logic [7:0] value);
         if (pos >= CARE_BITS) return 1'b1;
         if (!cfg.care_mask[pos]) return 1'b1;
         return expected_byte(pos) == value;
      endfunction

      // Advance the window by one accepted byte; queue an address on a hit
      function void note_byte(logic [7:0] value, logic first_of_region);
         int len;
         bit hit;
         logic [ADDR_BITS-1:0] addr;
         len = used_length();
         if (first_of_region) begin
            foreach (window[i]) window[i] = 8'h00;
            fill = 0;
            offset = '0;
         end
         if (fill < PATTERN_MAX) fill++;
         if (fill >= len) begin
            hit = position_ok(len - 1, value);
            for (int p = 0; hit && p + 1 < len; p++)
               hit = position_ok(p, window[len - 2 - p]);
            if (hit) begin
               addr = cfg.region_base + offset - ADDR_BITS'(len - 1);
               pending_matches.insert(pending_matches.size(), addr);
            end
         end
         for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
         window[0] = value;
         offset = offset + 1'b1;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         error_count++;
      endtask

      task check_match(logic [ADDR_BITS-1:0] got);
         logic [ADDR_BITS-1:0] want;
         if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("unexpected match_address %h", got));
         end else begin
            want = pending_matches.pop_front();
            if (got !== want)
               report_mismatch($sformatf("match_address got %h expected %h", got, want));
         end
      endtask

      function int pending();
         return pending_matches.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic req_region_begin = 1'b0;
   logic rsp_ready = 1'b0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   wire logic req_ready;
   wire logic rsp_valid;
   wire logic [ADDR_BITS-1:0] rsp_match_address;
   wire logic [CSR_DATA_BITS-1:0] prdata;
   wire logic pready;

   scan_scoreboard sb = new();
   int send_idle = 21;
   int recv_idle = 45;
   int quiet_cycles = 0;
   logic [7:0] burst [$];

   wildcard_byte_pattern_scanner_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_region_begin(req_region_begin),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_match_address(rsp_match_address),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data_byte, req_region_begin);
         if (rsp_valid && rsp_ready) sb.check_match(rsp_match_address);
      end
   end

   // Watchdog: too long with no handshake of any kind
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Register write with setup and access phases; the predictor follows at the write edge
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(idx) << 3;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [63:0] low, input logic [63:0] high,
                            input logic [15:0] mask, input logic [4:0] len,
                            input logic [ADDR_BITS-1:0] base);
      csr_write(REG_PATTERN_LOW, low);
      csr_write(REG_PATTERN_HIGH, high);
      csr_write(REG_CARE_MASK, 64'(mask));
      csr_write(REG_PATTERN_LEN, 64'(len));
      csr_write(REG_REGION_BASE, 64'(base));
   endtask

   // Present one item, with a random gap first, and hold it until taken
   task automatic send_byte(input logic [7:0] value, input logic first_of_region);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_region_begin <= first_of_region;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending, drain expected matches, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Next run of bytes: mostly pattern instances with random wildcards
   function automatic void queue_burst();
      int len;
      int kind;
      int n;
      len = sb.used_length();
      kind = $urandom_range(99);
      if (kind < 60) begin
         for (int p = 0; p < len; p++)
            if (sb.cfg.care_mask[p]) burst.insert(burst.size(), sb.expected_byte(p));
            else burst.insert(burst.size(), 8'($urandom));
      end else if (kind < 85) begin
         n = $urandom_range(len, 1);
         for (int k = 0; k < n; k++)
            burst.insert(burst.size(), sb.expected_byte($urandom_range(len - 1, 0)));
      end else begin
         n = $urandom_range(8, 1);
         for (int k = 0; k < n; k++) burst.insert(burst.size(), 8'($urandom));
      end
   endfunction

   initial begin
      int sent;
      int phase;
      logic [4:0] len;
      logic [15:0] mask;
      logic [ADDR_BITS-1:0] base;
      logic fresh;
      logic [7:0] value;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: length one, all wildcard, no region marker
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      wait_idle();

      // Full-length exact pattern; the match address wraps past the top
      write_all(64'hFF00_A55A_0F0F_8001, 64'h0001_02FE_7F80_C33C, 16'hFFFF, 5'd16,
                48'hFFFF_FFFF_FFFE);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      for (int p = 0; p < PATTERN_MAX; p++) send_byte(sb.expected_byte(p), 1'b0);
      wait_idle();

      // Length zero acts as one
      csr_write(REG_PATTERN_LEN, 64'd0);
      csr_write(REG_CARE_MASK, 64'h1);
      csr_write(REG_PATTERN_LOW, 64'hFF);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);

      // Random phases, each with its own settings
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         case (phase)
            0: len = 5'd16;
            1: len = 5'd1;
            2: len = 5'd0;
            3: len = 5'd31;
            4: len = 5'd17;
            default: len = ($urandom_range(99) < 85) ? 5'($urandom_range(16, 1))
                                                     : 5'($urandom_range(31, 0));
         endcase
         case ($urandom_range(9))
            0: mask = 16'hFFFF;
            1: mask = 16'h0000;
            default: mask = 16'($urandom);
         endcase
         if (phase == 0) mask = 16'hFFFF;
         case ($urandom_range(9))
            0: base = '0;
            1: base = '1;
            2: base = '1 - ADDR_BITS'($urandom_range(40));
            default: base = ADDR_BITS'({$urandom, $urandom});
         endcase
         write_all({$urandom, $urandom}, {$urandom, $urandom}, mask, len, base);
         // Half the phases keep the old window across the settings change
         fresh = 1'($urandom_range(1));
         burst.delete();
         for (int k = 0; k < PHASE_ITEMS && sent < RANDOM_ITEMS; k++) begin
            if (burst.size() == 0) queue_burst();
            value = burst.pop_front();
            if (sent == RANDOM_ITEMS / 3) begin
               send_idle = 45;
               recv_idle = 21;
            end else if (sent == 2 * RANDOM_ITEMS / 3) begin
               send_idle = 0;
               recv_idle = 0;
            end
            send_byte(value, (k == 0 && fresh) || ($urandom_range(99) < 3));
            sent++;
         end
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
